FILE: rtl/lz4bd_pkg.sv
// Package for the LZ4 block decompressor: sizes, error codes and item types.
// No dependencies; every rtl file imports it.
package lz4bd_pkg;

    localparam int WINDOW_DEPTH = 65536;
    localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
    localparam int LENGTH_BITS  = 32;
    localparam int PROD_BITS    = 17;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_OFF  = 3'd1;
    localparam logic [2:0] ERR_TRUNC    = 3'd2;
    localparam logic [2:0] ERR_LEN_OVF  = 3'd3;
    localparam logic [2:0] ERR_BUSY     = 3'd4;

    typedef logic [LENGTH_BITS-1:0] t_len;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
        logic       last_in;
    } t_in_item;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       busy_res;
        logic       block_done;
        logic [2:0] error_code;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_q_head;

endpackage

FILE: rtl/lz4bd_front.sv
// Front end: accepts input items into a two-entry queue for the decoder.
// Depends on lz4bd_pkg.
module lz4bd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lz4bd_pkg::t_in_item i_in_item,
    output lz4bd_pkg::t_q_head  o_head,
    input  logic                i_pop
);
    import lz4bd_pkg::*;

    t_in_item   r_ent [2];
    logic       r_rd_ptr, n_rd_ptr;
    logic       r_wr_ptr, n_wr_ptr;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    logic       pop;

    assign o_in_ready = (r_cnt != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_ent[r_rd_ptr];

    always_comb begin
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_cnt    = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr_ptr] <= i_in_item;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |=> (r_cnt <= 2'd1))
        else $error("queue grew by more than one item");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_pop) |=> (r_cnt == 2'd2))
        else $error("full queue lost an item without a pop");

endmodule

FILE: rtl/lz4bd_back.sv
// Back end: LZ4 sequence parser, 64 KiB history RAM and result register.
// Depends on lz4bd_pkg; fed by lz4bd_front.
module lz4bd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lz4bd_pkg::t_q_head   i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lz4bd_pkg::t_out_item o_out_item
);
    import lz4bd_pkg::*;

    localparam logic [2:0] PH_TOKEN    = 3'd0;
    localparam logic [2:0] PH_LITLEN   = 3'd1;
    localparam logic [2:0] PH_LITERALS = 3'd2;
    localparam logic [2:0] PH_OFF_LO   = 3'd3;
    localparam logic [2:0] PH_OFF_HI   = 3'd4;
    localparam logic [2:0] PH_MATCHLEN = 3'd5;
    localparam logic [2:0] PH_DRAIN    = 3'd6;
    localparam logic [2:0] PH_DONE     = 3'd7;

    localparam logic [PROD_BITS-1:0] PROD_MAX = {PROD_BITS{1'b1}};

    logic [ADDR_BITS-1:0]   r_wp, n_wp;
    logic [PROD_BITS-1:0]   r_prod, n_prod;
    logic [2:0]             r_phase, n_phase;
    logic [3:0]             r_nib, n_nib;
    t_len                   r_lit, n_lit;
    t_len                   r_mr, n_mr;
    logic [15:0]            r_dist, n_dist;

    logic [2:0]             ph;
    logic [2:0]             err;
    logic                   fin;
    logic                   push;
    logic                   cp;
    logic [LENGTH_BITS:0]   lsum;
    logic [LENGTH_BITS:0]   msum;
    t_len                   lit_dec;
    t_len                   mr_dec;
    logic [15:0]            dist_full;
    logic                   dist_bad;
    logic [ADDR_BITS-1:0]   raddr;
    logic                   issue;
    logic                   wr_en;
    logic                   hit;
    logic                   mode;
    logic [7:0]             b;
    logic                   l;

    logic [7:0]             r_mem [WINDOW_DEPTH];
    logic [7:0]             r_rdata;

    logic                   r_a_valid;
    logic                   r_a_push;
    logic                   r_a_copy;
    logic                   r_a_fwd;
    logic [7:0]             r_a_fwdb;
    logic [7:0]             r_a_lit;
    logic [ADDR_BITS-1:0]   r_a_waddr;
    logic                   r_a_busy;
    logic                   r_a_done;
    logic [2:0]             r_a_err;
    logic [7:0]             a_byte;

    assign mode = i_head.item.mode;
    assign b    = i_head.item.in_byte;
    assign l    = i_head.item.last_in;

    assign issue = i_head.valid && (!r_a_valid || i_out_ready);
    assign o_pop = issue;
    assign wr_en = r_a_valid && i_out_ready && r_a_push;

    assign lsum      = {1'b0, r_lit} + (LENGTH_BITS+1)'(b);
    assign msum      = {1'b0, r_mr} + (LENGTH_BITS+1)'(b)
                       + ((b != 8'hFF) ? (LENGTH_BITS+1)'(4) : '0);
    assign lit_dec   = (r_lit == '0) ? '0 : r_lit - t_len'(1);
    assign mr_dec    = (r_mr == '0) ? '0 : r_mr - t_len'(1);
    assign dist_full = {b, r_dist[7:0]};
    assign dist_bad  = (dist_full == 16'd0) || ({1'b0, dist_full} > r_prod)
                       || (32'(dist_full) > 32'(WINDOW_DEPTH));
    assign raddr     = r_wp - ADDR_BITS'(r_dist);
    assign hit       = wr_en && (r_a_waddr == raddr);

    always_comb begin
        n_wp    = r_wp;
        n_prod  = r_prod;
        n_phase = r_phase;
        n_nib   = r_nib;
        n_lit   = r_lit;
        n_mr    = r_mr;
        n_dist  = r_dist;
        ph      = r_phase;
        err     = ERR_NONE;
        fin     = 1'b0;
        push    = 1'b0;
        cp      = 1'b0;
        if (mode) begin
            if (r_phase == PH_DRAIN) begin
                cp   = 1'b1;
                push = 1'b1;
                n_mr = mr_dec;
                if (r_mr <= t_len'(1)) begin
                    n_phase = PH_TOKEN;
                end
            end
        end else if (r_phase == PH_DRAIN) begin
            err = ERR_BUSY;
        end else begin
            if (r_phase == PH_DONE) begin
                ph     = PH_TOKEN;
                n_prod = '0;
            end
            n_phase = ph;
            case (ph)
                PH_TOKEN: begin
                    n_nib = b[3:0];
                    n_lit = t_len'(b[7:4]);
                    if (b[7:4] == 4'hF) begin
                        n_phase = PH_LITLEN;
                        if (l) err = ERR_TRUNC;
                    end else if (b[7:4] == 4'h0) begin
                        if (l) fin = 1'b1;
                        else n_phase = PH_OFF_LO;
                    end else begin
                        n_phase = PH_LITERALS;
                        if (l) err = ERR_TRUNC;
                    end
                end
                PH_LITLEN: begin
                    if (lsum[LENGTH_BITS]) begin
                        n_lit = '1;
                        err   = ERR_LEN_OVF;
                    end else begin
                        n_lit = lsum[LENGTH_BITS-1:0];
                        if (b != 8'hFF) n_phase = PH_LITERALS;
                        if (l) err = ERR_TRUNC;
                    end
                end
                PH_LITERALS: begin
                    push  = 1'b1;
                    n_lit = lit_dec;
                    if (r_lit <= t_len'(1)) begin
                        if (l) fin = 1'b1;
                        else n_phase = PH_OFF_LO;
                    end else if (l) begin
                        err = ERR_TRUNC;
                    end
                end
                PH_OFF_LO: begin
                    n_dist  = {8'h00, b};
                    n_phase = PH_OFF_HI;
                    if (l) err = ERR_TRUNC;
                end
                PH_OFF_HI: begin
                    n_dist = dist_full;
                    if (dist_bad) begin
                        err = ERR_BAD_OFF;
                    end else if (l) begin
                        err = ERR_TRUNC;
                    end else if (r_nib == 4'hF) begin
                        n_mr    = t_len'(15);
                        n_phase = PH_MATCHLEN;
                    end else begin
                        n_mr    = t_len'(r_nib) + t_len'(4);
                        n_phase = PH_DRAIN;
                    end
                end
                PH_MATCHLEN: begin
                    if (msum[LENGTH_BITS]) begin
                        n_mr = '1;
                        err  = ERR_LEN_OVF;
                    end else begin
                        n_mr = msum[LENGTH_BITS-1:0];
                        if (l) err = ERR_TRUNC;
                        else if (b != 8'hFF) n_phase = PH_DRAIN;
                    end
                end
                default: begin
                end
            endcase
        end
        if (push) begin
            n_wp = r_wp + ADDR_BITS'(1);
            if (n_prod != PROD_MAX) n_prod = n_prod + PROD_BITS'(1);
        end
        if (err == ERR_BAD_OFF || err == ERR_TRUNC || err == ERR_LEN_OVF) begin
            fin = 1'b1;
        end
        if (fin) begin
            n_phase = PH_DONE;
            n_lit   = '0;
            n_mr    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_prod  <= '0;
            r_phase <= PH_TOKEN;
            r_nib   <= '0;
            r_lit   <= '0;
            r_mr    <= '0;
            r_dist  <= '0;
        end else if (issue) begin
            r_wp    <= n_wp;
            r_prod  <= n_prod;
            r_phase <= n_phase;
            r_nib   <= n_nib;
            r_lit   <= n_lit;
            r_mr    <= n_mr;
            r_dist  <= n_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_a_waddr] <= a_byte;
        end
        if (issue && cp) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (issue) begin
            r_a_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_push  <= push;
            r_a_copy  <= cp;
            r_a_fwd   <= cp && hit;
            r_a_fwdb  <= a_byte;
            r_a_lit   <= b;
            r_a_waddr <= r_wp;
            r_a_busy  <= (n_phase == PH_DRAIN);
            r_a_done  <= fin;
            r_a_err   <= err;
        end
    end

    assign a_byte = r_a_copy ? (r_a_fwd ? r_a_fwdb : r_rdata) : r_a_lit;

    assign o_out_valid           = r_a_valid;
    assign o_out_item.out_valid  = r_a_push;
    assign o_out_item.out_byte   = r_a_push ? a_byte : 8'h00;
    assign o_out_item.busy_res   = r_a_busy;
    assign o_out_item.block_done = r_a_done;
    assign o_out_item.error_code = r_a_err;

    a_err_ends_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && (r_a_err == ERR_BAD_OFF || r_a_err == ERR_TRUNC
                       || r_a_err == ERR_LEN_OVF)) |-> r_a_done)
        else $error("fatal error without block end");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> !(r_a_done && r_a_busy))
        else $error("block ended while match bytes remain");

    a_drain_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DRAIN) |-> (r_mr != '0))
        else $error("drain phase with no match bytes left");

    a_fwd_on_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_fwd) |-> (r_a_copy && r_a_push))
        else $error("forward flag on a non-copy item");

    a_copy_busy_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_err == ERR_BUSY) |-> (r_a_busy && !r_a_push))
        else $error("busy error outside drain phase");

endmodule

FILE: rtl/lz4_block_decompressor_top.sv
// Top level of the LZ4 block decompressor.
// Depends on lz4bd_pkg, lz4bd_front and lz4bd_back.
//
// Input channel (i_in_valid / o_in_ready / i_in_item): one item per accept,
// either a compressed byte (mode 0) or a drain tick (mode 1) that copies one
// pending match byte out of the history window.
// Output channel (o_out_valid / i_out_ready / o_out_item): exactly one result
// item per input item, in order.
// An accepted item is held in the queue until the parser issues it, and its
// result is then offered from the registered output stage.
// Throughput: one item per cycle while results are taken, set by the single
// read and single write port of the 64 KiB history RAM, each used at most
// once per item; a copy reading the byte written in the same cycle is forwarded.
// A two-entry queue in front of the parser keeps o_in_ready high while one
// result waits on the output register; when the receiver stalls, the queue
// fills and o_in_ready drops after two more items.
// Reset clears the parser to expect a token and empties queue and output;
// the history RAM is not cleared and needs no clearing pass.
module lz4_block_decompressor_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lz4bd_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lz4bd_pkg::t_out_item o_out_item
);
    import lz4bd_pkg::*;

    t_q_head head;
    logic    pop;

    lz4bd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_head     (head),
        .i_pop      (pop)
    );

    lz4bd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
